// ===== sv/hwcc_pkg.sv =====
package hwcc_pkg;

  // Heat source codes; code three counts as "other"
  localparam logic [1:0] SRC_WOOD = 2'd1;
  localparam logic [1:0] SRC_OIL  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WATER_SETPOINT = 2'd0;
  localparam logic [1:0] CFG_OIL_HYSTERESIS = 2'd1;
  localparam logic [1:0] CFG_DWELL_LIMIT    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [6:0] SETPOINT_RST    = 7'd55;
  localparam logic [5:0] HYSTERESIS_RST  = 6'd5;
  localparam logic [7:0] DWELL_LIMIT_RST = 8'd120;

  // Temperature margins in degrees
  localparam logic signed [9:0] WOOD_FULL_MARGIN = 10'sd3;
  localparam logic signed [9:0] BUFFER_MARGIN    = 10'sd6;
  localparam logic signed [9:0] BOILER_MARGIN    = 10'sd5;

  localparam logic [7:0] DWELL_MAX = 8'd255;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_CHOOSE      = 3'd1,
    MODE_WOOD_FULL   = 3'd2,
    MODE_WOOD_DECIDE = 3'd3,
    MODE_WOOD_DWELL  = 3'd4,
    MODE_OIL_FULL    = 3'd5,
    MODE_OIL_CHARGE  = 3'd6
  } mode_t;

  typedef struct packed {
    logic              enable;
    logic [1:0]        heat_source;
    logic signed [7:0] water_temp;
    logic signed [7:0] buffer_temp;
    logic signed [7:0] boiler_temp;
    logic              tick;
  } in_item_t;

  typedef struct packed {
    logic       pump_on;
    logic       burner_on;
    logic [2:0] mode_now;
  } out_item_t;

  typedef struct packed {
    logic [6:0] water_setpoint;
    logic [5:0] oil_hysteresis;
    logic [7:0] dwell_limit;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    logic       pump;
    logic       burner;
    logic [7:0] dwell_count;
  } ctrl_state_t;

endpackage

// ===== sv/hot_water_charge_controller.sv =====
// Hot water charge controller. Each request is one evaluation of the tank
// controller (enable, heat source, water/buffer/boiler temperatures, tick)
// and yields exactly one result: pump drive, burner request and the mode
// after the step. The state update is one pass of logic into the state and
// result registers, so a request is taken every cycle and its result shows
// on the following cycle; the only limit on throughput is the result
// register, which takes a new request whenever it is empty or being drained
// in the same cycle. Config registers (setpoint, oil hysteresis, dwell limit)
// are written via cfg_we/cfg_index/cfg_wdata, an index past the last ignored;
// the user must write them only while the block is idle; nothing enforces it.
module hot_water_charge_controller (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hwcc_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hwcc_pkg::out_item_t   out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata
);

  hwcc_pkg::cfg_t        cfg_r;
  hwcc_pkg::ctrl_state_t state_r;
  hwcc_pkg::ctrl_state_t state_nxt;
  hwcc_pkg::out_item_t   out_data_r;
  logic                  out_valid_r;
  logic                  in_take;

  // Result register frees up when empty or drained this cycle
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.water_setpoint <= hwcc_pkg::SETPOINT_RST;
      cfg_r.oil_hysteresis <= hwcc_pkg::HYSTERESIS_RST;
      cfg_r.dwell_limit    <= hwcc_pkg::DWELL_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hwcc_pkg::CFG_WATER_SETPOINT: cfg_r.water_setpoint <= cfg_wdata[6:0];
        hwcc_pkg::CFG_OIL_HYSTERESIS: cfg_r.oil_hysteresis <= cfg_wdata[5:0];
        hwcc_pkg::CFG_DWELL_LIMIT:    cfg_r.dwell_limit    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next-state logic
  hwcc_step u_step (
    .cur  (state_r),
    .item (in_data),
    .cfg  (cfg_r),
    .nxt  (state_nxt)
  );

  // Controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= hwcc_pkg::MODE_IDLE;
      state_r.pump        <= 1'b0;
      state_r.burner      <= 1'b0;
      state_r.dwell_count <= '0;
    end else if (in_take) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data_r.pump_on   <= state_nxt.pump;
      out_data_r.burner_on <= state_nxt.burner;
      out_data_r.mode_now  <= 3'(state_nxt.mode);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/hwcc_step.sv =====
module hwcc_step (
  input  hwcc_pkg::ctrl_state_t cur,
  input  hwcc_pkg::in_item_t    item,
  input  hwcc_pkg::cfg_t        cfg,
  output hwcc_pkg::ctrl_state_t nxt
);

  logic signed [9:0] water_s;
  logic signed [9:0] buffer_s;
  logic signed [9:0] boiler_s;
  logic signed [9:0] sp_s;
  logic signed [9:0] hyst_s;
  logic              wood_sel;
  logic              oil_sel;
  logic              below_wood;
  logic              below_oil;
  logic              at_setpoint;
  logic              buffer_hot;
  logic              boiler_hot;
  logic              dwell_done;
  hwcc_pkg::ctrl_state_t rule;

  // Sign-extend temperatures, zero-extend settings
  assign water_s  = {{2{item.water_temp[7]}}, item.water_temp};
  assign buffer_s = {{2{item.buffer_temp[7]}}, item.buffer_temp};
  assign boiler_s = {{2{item.boiler_temp[7]}}, item.boiler_temp};
  assign sp_s     = {3'b000, cfg.water_setpoint};
  assign hyst_s   = {4'b0000, cfg.oil_hysteresis};

  assign wood_sel    = (item.heat_source == hwcc_pkg::SRC_WOOD);
  assign oil_sel     = (item.heat_source == hwcc_pkg::SRC_OIL);
  assign below_wood  = water_s < (sp_s - hwcc_pkg::WOOD_FULL_MARGIN);
  assign below_oil   = water_s < (sp_s - hyst_s);
  assign at_setpoint = water_s >= sp_s;
  assign buffer_hot  = (buffer_s - hwcc_pkg::BUFFER_MARGIN) > water_s;
  assign boiler_hot  = (water_s + hwcc_pkg::BOILER_MARGIN) < boiler_s;
  assign dwell_done  = cur.dwell_count > cfg.dwell_limit;

  // State rule for the current mode
  always_comb begin
    rule = cur;
    unique case (cur.mode)
      hwcc_pkg::MODE_IDLE: begin
        if (item.enable) rule.mode = hwcc_pkg::MODE_CHOOSE;
      end
      hwcc_pkg::MODE_CHOOSE: begin
        if (!item.enable)  rule.mode = hwcc_pkg::MODE_IDLE;
        else if (wood_sel) rule.mode = hwcc_pkg::MODE_WOOD_FULL;
        else if (oil_sel)  rule.mode = hwcc_pkg::MODE_OIL_FULL;
      end
      hwcc_pkg::MODE_WOOD_FULL: begin
        if (!item.enable)    rule.mode = hwcc_pkg::MODE_IDLE;
        else if (!wood_sel)  rule.mode = hwcc_pkg::MODE_CHOOSE;
        else if (below_wood) rule.mode = hwcc_pkg::MODE_WOOD_DECIDE;
      end
      hwcc_pkg::MODE_WOOD_DECIDE: begin
        if (!item.enable) begin
          rule.pump = 1'b0;
          rule.mode = hwcc_pkg::MODE_IDLE;
        end else if (!wood_sel) begin
          rule.pump = 1'b0;
          rule.mode = hwcc_pkg::MODE_CHOOSE;
        end else if (at_setpoint) begin
          rule.pump = 1'b0;
          rule.mode = hwcc_pkg::MODE_WOOD_FULL;
        end else begin
          // decide once, then hold for the dwell time
          rule.pump        = buffer_hot;
          rule.mode        = hwcc_pkg::MODE_WOOD_DWELL;
          rule.dwell_count = '0;
        end
      end
      hwcc_pkg::MODE_WOOD_DWELL: begin
        if (dwell_done) rule.mode = hwcc_pkg::MODE_WOOD_DECIDE;
      end
      hwcc_pkg::MODE_OIL_FULL: begin
        if (!item.enable)  rule.mode = hwcc_pkg::MODE_IDLE;
        else if (!oil_sel) rule.mode = hwcc_pkg::MODE_CHOOSE;
        else if (below_oil) begin
          rule.mode   = hwcc_pkg::MODE_OIL_CHARGE;
          rule.burner = 1'b1;
        end
      end
      hwcc_pkg::MODE_OIL_CHARGE: begin
        if (!item.enable || !oil_sel) begin
          rule.mode   = item.enable ? hwcc_pkg::MODE_CHOOSE : hwcc_pkg::MODE_IDLE;
          rule.pump   = 1'b0;
          rule.burner = 1'b0;
        end else if (at_setpoint) begin
          rule.mode   = hwcc_pkg::MODE_OIL_FULL;
          rule.pump   = 1'b0;
          rule.burner = 1'b0;
        end else if (boiler_hot) begin
          rule.pump = 1'b1;
        end
      end
      default: begin
        // unused mode code falls back to idle, outputs kept
        rule.mode = hwcc_pkg::MODE_IDLE;
      end
    endcase
  end

  // Tick advances the dwell counter after the rule, saturating
  always_comb begin
    nxt = rule;
    if (item.tick && (rule.dwell_count != hwcc_pkg::DWELL_MAX)) begin
      nxt.dwell_count = rule.dwell_count + 8'd1;
    end
  end

endmodule

// ===== verif/tb_hot_water_charge_controller.sv =====
module tb_hot_water_charge_controller;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  hwcc_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  hwcc_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = hwcc_pkg::CFG_WATER_SETPOINT;
  logic [7:0]          cfg_wdata = '0;

  hot_water_charge_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be sent and controller replies still owed
  hwcc_pkg::in_item_t  tank_reqs[$];
  hwcc_pkg::out_item_t tank_replies_due[$];

  // Shadow of the controller: registers and state
  logic [6:0]      sp_cfg = hwcc_pkg::SETPOINT_RST;
  logic [5:0]      hyst_cfg = hwcc_pkg::HYSTERESIS_RST;
  logic [7:0]      dwell_cfg = hwcc_pkg::DWELL_LIMIT_RST;
  hwcc_pkg::mode_t ctl_mode = hwcc_pkg::MODE_IDLE;
  logic            ctl_pump = 1'b0;
  logic            ctl_burner = 1'b0;
  logic [7:0]      ctl_dwell = '0;

  int  fail_count = 0;
  int  sent_count = 0;
  int  checked_count = 0;
  int  setting_count = 0;
  logic [7:0] modes_seen = '0;
  bit  calm = 1'b0;
  logic [1:0] src_now = hwcc_pkg::SRC_WOOD;

  // One evaluation of the tank controller; updates the shadow state
  function automatic hwcc_pkg::out_item_t advance_controller(hwcc_pkg::in_item_t req);
    int water, buffer, boiler, sp;
    hwcc_pkg::out_item_t res;
    water  = $signed(req.water_temp);
    buffer = $signed(req.buffer_temp);
    boiler = $signed(req.boiler_temp);
    sp     = int'(sp_cfg);
    case (ctl_mode)
      hwcc_pkg::MODE_IDLE: begin
        if (req.enable) ctl_mode = hwcc_pkg::MODE_CHOOSE;
      end
      hwcc_pkg::MODE_CHOOSE: begin
        if (!req.enable) ctl_mode = hwcc_pkg::MODE_IDLE;
        else if (req.heat_source == hwcc_pkg::SRC_WOOD) ctl_mode = hwcc_pkg::MODE_WOOD_FULL;
        else if (req.heat_source == hwcc_pkg::SRC_OIL) ctl_mode = hwcc_pkg::MODE_OIL_FULL;
      end
      hwcc_pkg::MODE_WOOD_FULL: begin
        if (!req.enable) ctl_mode = hwcc_pkg::MODE_IDLE;
        else if (req.heat_source != hwcc_pkg::SRC_WOOD) ctl_mode = hwcc_pkg::MODE_CHOOSE;
        else if (water < sp - int'(hwcc_pkg::WOOD_FULL_MARGIN))
          ctl_mode = hwcc_pkg::MODE_WOOD_DECIDE;
      end
      hwcc_pkg::MODE_WOOD_DECIDE: begin
        if (!req.enable) begin
          ctl_pump = 1'b0;
          ctl_mode = hwcc_pkg::MODE_IDLE;
        end else if (req.heat_source != hwcc_pkg::SRC_WOOD) begin
          ctl_pump = 1'b0;
          ctl_mode = hwcc_pkg::MODE_CHOOSE;
        end else if (water >= sp) begin
          ctl_pump = 1'b0;
          ctl_mode = hwcc_pkg::MODE_WOOD_FULL;
        end else begin
          ctl_pump  = (buffer - int'(hwcc_pkg::BUFFER_MARGIN) > water);
          ctl_mode  = hwcc_pkg::MODE_WOOD_DWELL;
          ctl_dwell = '0;
        end
      end
      // dwell ignores enable and source
      hwcc_pkg::MODE_WOOD_DWELL: begin
        if (ctl_dwell > dwell_cfg) ctl_mode = hwcc_pkg::MODE_WOOD_DECIDE;
      end
      hwcc_pkg::MODE_OIL_FULL: begin
        if (!req.enable) ctl_mode = hwcc_pkg::MODE_IDLE;
        else if (req.heat_source != hwcc_pkg::SRC_OIL) ctl_mode = hwcc_pkg::MODE_CHOOSE;
        else if (water < sp - int'(hyst_cfg)) begin
          ctl_mode   = hwcc_pkg::MODE_OIL_CHARGE;
          ctl_burner = 1'b1;
        end
      end
      hwcc_pkg::MODE_OIL_CHARGE: begin
        if (!req.enable || req.heat_source != hwcc_pkg::SRC_OIL) begin
          ctl_mode   = req.enable ? hwcc_pkg::MODE_CHOOSE : hwcc_pkg::MODE_IDLE;
          ctl_pump   = 1'b0;
          ctl_burner = 1'b0;
        end else begin
          // pump latches on, drops only when the tank is charged
          if (water + int'(hwcc_pkg::BOILER_MARGIN) < boiler) ctl_pump = 1'b1;
          if (water >= sp) begin
            ctl_burner = 1'b0;
            ctl_pump   = 1'b0;
            ctl_mode   = hwcc_pkg::MODE_OIL_FULL;
          end
        end
      end
      default: ctl_mode = hwcc_pkg::MODE_IDLE;
    endcase
    if (req.tick && ctl_dwell != hwcc_pkg::DWELL_MAX) ctl_dwell = ctl_dwell + 8'd1;
    res.pump_on   = ctl_pump;
    res.burner_on = ctl_burner;
    res.mode_now  = ctl_mode;
    return res;
  endfunction

  // Mostly zero, some short, a few long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [7:0] to_temp(int v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return v[7:0];
  endfunction

  function automatic hwcc_pkg::in_item_t eval_req(int en, int src, int water, int buffer,
                                                  int boiler, int tick);
    hwcc_pkg::in_item_t req;
    req.enable      = en[0];
    req.heat_source = src[1:0];
    req.water_temp  = to_temp(water);
    req.buffer_temp = to_temp(buffer);
    req.boiler_temp = to_temp(boiler);
    req.tick        = tick[0];
    return req;
  endfunction

  // Random evaluation: mostly plausible tank readings near the thresholds
  function automatic hwcc_pkg::in_item_t rand_eval(int tick_pct);
    hwcc_pkg::in_item_t req;
    logic [31:0] raw;
    int water;
    if ($urandom_range(0, 99) < 8) begin
      raw = $urandom;
      req = raw[$bits(hwcc_pkg::in_item_t)-1:0];
      return req;
    end
    if ($urandom_range(0, 14) == 0) src_now = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0)
      water = int'(sp_cfg) + $urandom_range(0, 11) - 8;
    else
      water = int'(sp_cfg) - int'(hyst_cfg) + $urandom_range(0, 6) - 4;
    return eval_req($urandom_range(0, 19) != 0, src_now, water,
                    water + $urandom_range(0, 16) - 2,
                    water + $urandom_range(0, 14) - 2,
                    $urandom_range(0, 99) < tick_pct);
  endfunction

  // Request driver
  always @(posedge clk) begin
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        tank_replies_due.push_back(advance_controller(in_data));
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tank_reqs.size() > 0) begin
          in_data  <= tank_reqs.pop_front();
          in_valid <= 1'b1;
          gap_left = calm ? 0 : pick_pause();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor and stall generator
  always @(posedge clk) begin
    int stall_left;
    hwcc_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        modes_seen[out_data.mode_now] = 1'b1;
        if (tank_replies_due.size() == 0) begin
          $error("reply with no request outstanding: %p", out_data);
          fail_count++;
        end else begin
          want = tank_replies_due.pop_front();
          checked_count++;
          if (out_data.pump_on !== want.pump_on) begin
            $error("pump_on: expected %0d, got %0d", want.pump_on, out_data.pump_on);
            fail_count++;
          end
          if (out_data.burner_on !== want.burner_on) begin
            $error("burner_on: expected %0d, got %0d", want.burner_on, out_data.burner_on);
            fail_count++;
          end
          if (out_data.mode_now !== want.mode_now) begin
            $error("mode_now: expected %0d, got %0d", want.mode_now, out_data.mode_now);
            fail_count++;
          end
        end
      end
      if (stall_left == 0 && !calm) stall_left = pick_pause();
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hold off until every request is sent and answered
  task automatic drain();
    @(negedge clk);
    while (tank_reqs.size() != 0 || in_valid || tank_replies_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hwcc_pkg::CFG_WATER_SETPOINT: sp_cfg = val[6:0];
      hwcc_pkg::CFG_OIL_HYSTERESIS: hyst_cfg = val[5:0];
      hwcc_pkg::CFG_DWELL_LIMIT:    dwell_cfg = val;
      default: ;
    endcase
  endtask

  task automatic run_setting(int sp, int hyst, int dwell, int count, int tick_pct,
                             bit quiet);
    write_reg(hwcc_pkg::CFG_WATER_SETPOINT, 8'(sp));
    write_reg(hwcc_pkg::CFG_OIL_HYSTERESIS, 8'(hyst));
    write_reg(hwcc_pkg::CFG_DWELL_LIMIT, 8'(dwell));
    setting_count++;
    calm = quiet;
    for (int i = 0; i < count; i++) tank_reqs.push_back(rand_eval(tick_pct));
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk through every mode and threshold edge (setpoint 55,
    // hysteresis 5, dwell limit 2)
    write_reg(hwcc_pkg::CFG_DWELL_LIMIT, 8'd2);
    setting_count++;
    calm = 1'b1;
    tank_reqs.push_back(eval_req(0, 0, -128, -128, -128, 0));
    tank_reqs.push_back(eval_req(1, 3, 127, 127, 127, 1));
    tank_reqs.push_back(eval_req(1, 3, 0, 0, 0, 0));        // source three is "other"
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 55, 0, 0, 0));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 52, 0, 0, 1)); // just not below full
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 51, 0, 0, 0));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 40, 46, 0, 1)); // decide plus tick
    tank_reqs.push_back(eval_req(0, hwcc_pkg::SRC_OIL, -1, -1, -1, 1)); // dwell ignores inputs
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 0, 0, 0, 1));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 0, 0, 0, 0));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 40, 47, 0, 0)); // buffer hot enough
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 0, 0, 0, 1));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 0, 0, 0, 1));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 0, 0, 0, 1));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 0, 0, 0, 0));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_WOOD, 55, 127, 0, 0)); // tank full
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_OIL, 55, 0, 0, 0));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_OIL, 50, 0, 0, 0));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_OIL, 50, 0, 0, 0));   // hysteresis edge
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_OIL, 49, 0, 54, 0));  // burner fires
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_OIL, 49, 0, 54, 0));  // boiler not hot
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_OIL, 49, 0, 55, 0));  // pump starts
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_OIL, 50, 0, -128, 0)); // pump holds
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_OIL, 55, 0, 0, 0));
    tank_reqs.push_back(eval_req(1, hwcc_pkg::SRC_OIL, -128, 0, 0, 0));
    tank_reqs.push_back(eval_req(1, 0, -128, 0, 127, 0));    // source change clears
    drain();

    // Random settings, extremes first; the dwell-forever setting saturates
    // the counter
    run_setting(55, 5, 6, 250, 50, 1'b0);
    run_setting(127, 63, 255, 400, 85, 1'b0);
    run_setting(0, 0, 0, 200, 50, 1'b1);
    run_setting($urandom_range(0, 127), $urandom_range(0, 63), $urandom_range(0, 12),
                200, 50, 1'b0);
    run_setting($urandom_range(0, 127), $urandom_range(0, 63), $urandom_range(0, 12),
                200, 30, 1'b0);

    repeat (10) @(posedge clk);
    $display("Sent %0d evaluations under %0d register settings, %0d replies checked",
             sent_count, setting_count, checked_count);
    $display("Modes reported: %b (bit per mode)", modes_seen);
    if (fail_count == 0 && tank_replies_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d replies outstanding", tank_replies_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
